[rtl/core/dbmf_pkg.sv]
// shared types and constants of the duplicate-filtering message fifo
package dbmf_pkg;

    localparam int MSG_W = 16;
    localparam int ACT_W = 2;
    localparam int CAP_W = 5;
    localparam int CNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // value reported for head and tail while the queue is empty
    localparam logic signed [MSG_W-1:0] HEAD_EMPTY = -16'sd1;
    localparam logic signed [MSG_W-1:0] TAIL_EMPTY = 16'sd0;

    typedef enum logic [ACT_W-1:0] {
        ACT_OFFER = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic rd_oldest;
        logic rd_tail;
        logic take_evict;
        logic take_pop;
        logic do_write;
        logic do_clear;
        logic cap_head;
        logic load_out;
    } dbmf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic dup_found;
        logic full;
        logic nonempty;
        logic out_free;
    } dbmf_stat_t;

    // one result item
    typedef struct packed {
        logic                    was_duplicate;
        logic                    was_stored;
        logic                    did_evict;
        logic signed [MSG_W-1:0] evicted_value;
        logic signed [MSG_W-1:0] popped_value;
        logic signed [MSG_W-1:0] head_value;
        logic signed [MSG_W-1:0] tail_value;
        logic [CNT_W-1:0]        occupancy;
        logic                    is_empty;
    } dbmf_res_t;

endpackage

[rtl/core/dbmf_in_if.sv]
// input channel: action and offered message value
interface dbmf_in_if import dbmf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [MSG_W-1:0] message_value;

    modport source (output valid, output action, output message_value, input ready);
    modport sink (input valid, input action, input message_value, output ready);
endinterface

[rtl/core/dbmf_out_if.sv]
// output channel: one status item per accepted input item
interface dbmf_out_if import dbmf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    was_duplicate;
    logic                    was_stored;
    logic                    did_evict;
    logic signed [MSG_W-1:0] evicted_value;
    logic signed [MSG_W-1:0] popped_value;
    logic signed [MSG_W-1:0] head_value;
    logic signed [MSG_W-1:0] tail_value;
    logic [CNT_W-1:0]        occupancy;
    logic                    is_empty;

    modport source (
        output valid, output was_duplicate, output was_stored, output did_evict,
        output evicted_value, output popped_value, output head_value,
        output tail_value, output occupancy, output is_empty,
        input ready
    );
    modport sink (
        input valid, input was_duplicate, input was_stored, input did_evict,
        input evicted_value, input popped_value, input head_value,
        input tail_value, input occupancy, input is_empty,
        output ready
    );
endinterface

[rtl/core/dedup_bounded_message_fifo.sv]
// top level of the duplicate-filtering bounded message fifo
//
// Keeps recent signed 16-bit messages in arrival order in a ring of DEPTH
// entries, held in a single-port-read, single-port-write memory. An offer
// (action 0) is checked against every stored entry, one entry per cycle
// through the memory read port, and dropped when it matches; otherwise it is
// appended, evicting the oldest entry first when the occupancy has reached
// the capacity register (0 acts as 1, values above DEPTH act as DEPTH). Pop
// (action 1) removes the oldest entry, clear (action 2) empties the queue,
// and every item returns one status item with head, tail and occupancy.
// One item is processed at a time. An offer scans the stored entries through
// the memory read port, then reads and takes the oldest entry when it evicts,
// and writes the new one; a pop of a non-empty queue reads and takes the
// oldest entry and a clear empties the queue. Every item then reads head and
// tail, and waits while the receiver still holds the result register. The
// result sits in an output register, and the next item is accepted in the
// cycle after the result is loaded there. The capacity register may be
// written only while no item is in flight; the memory needs no clearing
// pass after reset.
module dedup_bounded_message_fifo import dbmf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    dbmf_in_if.sink          in_ch,
    dbmf_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    dbmf_cmd_t  cmd;
    dbmf_stat_t stat;
    dbmf_res_t  res;
    logic       in_ready;
    logic       out_valid;

    // controller
    dbmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    dbmf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_message (in_ch.message_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ch.ready),
        .out_valid  (out_valid),
        .res        (res)
    );

    // channel hookup
    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid;
    assign out_ch.was_duplicate = res.was_duplicate;
    assign out_ch.was_stored    = res.was_stored;
    assign out_ch.did_evict     = res.did_evict;
    assign out_ch.evicted_value = res.evicted_value;
    assign out_ch.popped_value  = res.popped_value;
    assign out_ch.head_value    = res.head_value;
    assign out_ch.tail_value    = res.tail_value;
    assign out_ch.occupancy     = res.occupancy;
    assign out_ch.is_empty      = res.is_empty;

    // one item in flight: an accepted item closes the input until its result is loaded
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready
    ) else $error("input accepted while an item is in flight");

    // a dropped duplicate is never also stored or evicting
    a_dup_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.was_duplicate) |-> (!out_ch.was_stored && !out_ch.did_evict)
    ) else $error("duplicate reported together with store or evict");

    // eviction only happens on the way to an append
    a_evict_stores: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.did_evict) |-> out_ch.was_stored
    ) else $error("eviction without append");

    // empty status matches the head and tail placeholders
    a_empty_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.is_empty) |->
            (out_ch.occupancy == '0 && out_ch.head_value == HEAD_EMPTY
             && out_ch.tail_value == TAIL_EMPTY)
    ) else $error("empty status inconsistent");

    // occupancy never exceeds the ring
    a_occ_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((DEPTH > 31) || (32'(out_ch.occupancy) <= DEPTH))
    ) else $error("occupancy beyond ring size");

endmodule

[rtl/core/dbmf_ctrl.sv]
// sequencing state machine of the duplicate-filtering message fifo
module dbmf_ctrl import dbmf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ACT_W-1:0] in_action,
    output logic             in_ready,
    input  dbmf_stat_t       stat,
    output dbmf_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_EVICT_RD,
        S_EVICT_TAKE,
        S_WRITE,
        S_POP_RD,
        S_POP_TAKE,
        S_CLEAR,
        S_HEAD_RD,
        S_TAIL_RD,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (action_t'(in_action))
                        ACT_OFFER: state_next = S_SCAN;
                        ACT_POP:   state_next = stat.nonempty ? S_POP_RD : S_HEAD_RD;
                        ACT_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_HEAD_RD;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.dup_found)
                        state_next = S_HEAD_RD;
                    else if (stat.full)
                        state_next = S_EVICT_RD;
                    else
                        state_next = S_WRITE;
                end
            end
            S_EVICT_RD:
            begin
                cmd.rd_oldest = 1'b1;
                state_next    = S_EVICT_TAKE;
            end
            S_EVICT_TAKE:
            begin
                cmd.take_evict = 1'b1;
                state_next     = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.do_write = 1'b1;
                state_next   = S_HEAD_RD;
            end
            S_POP_RD:
            begin
                cmd.rd_oldest = 1'b1;
                state_next    = S_POP_TAKE;
            end
            S_POP_TAKE:
            begin
                cmd.take_pop = 1'b1;
                state_next   = S_HEAD_RD;
            end
            S_CLEAR:
            begin
                cmd.do_clear = 1'b1;
                state_next   = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                cmd.rd_oldest = 1'b1;
                state_next    = S_TAIL_RD;
            end
            S_TAIL_RD:
            begin
                cmd.cap_head = 1'b1;
                cmd.rd_tail  = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/dbmf_dpath.sv]
// ring storage, pointers, duplicate scan and result register
module dbmf_dpath import dbmf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_wdata,
    input  logic signed [MSG_W-1:0] in_message,
    input  dbmf_cmd_t               cmd,
    output dbmf_stat_t              stat,
    input  logic                    out_ready,
    output logic                    out_valid,
    output dbmf_res_t               res
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(CAP_MAX);

    logic [MSG_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [PTR_W-1:0]        oldest_reg;
    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    rd_pend_reg;
    logic                    dup_reg;
    logic                    stored_reg;
    logic                    evict_reg;
    logic                    out_valid_reg;
    logic signed [MSG_W-1:0] msg_reg;
    logic signed [MSG_W-1:0] rd_data_reg;
    logic signed [MSG_W-1:0] evicted_reg;
    logic signed [MSG_W-1:0] popped_reg;
    logic signed [MSG_W-1:0] head_reg;
    dbmf_res_t               res_reg;

    logic [CAP_W-1:0] cap_eff;
    logic             scan_issue;
    logic             rd_en;
    logic [CNT_W-1:0] rd_off;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] next_oldest;
    logic             take;
    logic             nonempty;

    // ring index of the entry at a given distance from the oldest one
    function automatic logic [PTR_W-1:0] ring_slot(
        input logic [PTR_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= DEPTH_S)
            s = s - DEPTH_S;
        return s[PTR_W-1:0];
    endfunction

    // effective capacity, clamped to one and to the ring size
    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = CAP_W'(1);
        else if (capacity_reg > CAP_LIM)
            cap_eff = CAP_LIM;
        else
            cap_eff = capacity_reg;
    end

    assign nonempty   = (count_reg != '0);
    assign scan_issue = cmd.scan && (scan_idx_reg != count_reg);
    assign take       = cmd.take_evict || cmd.take_pop;

    // read port address select
    always_comb
    begin
        rd_off = '0;
        if (cmd.scan)
            rd_off = scan_idx_reg;
        else if (cmd.rd_tail)
            rd_off = count_reg - CNT_W'(1);
    end

    assign rd_en       = scan_issue || cmd.rd_oldest || (cmd.rd_tail && nonempty);
    assign rd_addr     = ring_slot(oldest_reg, rd_off);
    assign wr_addr     = ring_slot(oldest_reg, count_reg);
    assign next_oldest = ring_slot(oldest_reg, CNT_W'(1));

    // ring memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
            mem[wr_addr] <= msg_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // control state: capacity, occupancy, oldest pointer, scan and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            oldest_reg    <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            stored_reg    <= 1'b0;
            evict_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;

            if (cmd.accept)
            begin
                scan_idx_reg <= '0;
                dup_reg      <= 1'b0;
                stored_reg   <= 1'b0;
                evict_reg    <= 1'b0;
            end
            else if (scan_issue)
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);

            rd_pend_reg <= scan_issue;

            // compare the entry read in the previous cycle
            if (cmd.scan && rd_pend_reg && (rd_data_reg == msg_reg))
                dup_reg <= 1'b1;

            if (cmd.take_evict)
                evict_reg <= 1'b1;
            if (cmd.do_write)
                stored_reg <= 1'b1;

            if (cmd.do_clear)
            begin
                count_reg  <= '0;
                oldest_reg <= '0;
            end
            else if (take)
            begin
                count_reg  <= count_reg - CNT_W'(1);
                oldest_reg <= next_oldest;
            end
            else if (cmd.do_write)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item payload and result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            msg_reg     <= in_message;
            evicted_reg <= '0;
            popped_reg  <= '0;
        end
        if (cmd.take_evict)
            evicted_reg <= rd_data_reg;
        if (cmd.take_pop)
            popped_reg <= rd_data_reg;
        if (cmd.cap_head)
            head_reg <= rd_data_reg;
        if (cmd.load_out)
        begin
            res_reg.was_duplicate <= dup_reg;
            res_reg.was_stored    <= stored_reg;
            res_reg.did_evict     <= evict_reg;
            res_reg.evicted_value <= evicted_reg;
            res_reg.popped_value  <= popped_reg;
            res_reg.head_value    <= nonempty ? head_reg : HEAD_EMPTY;
            res_reg.tail_value    <= nonempty ? rd_data_reg : TAIL_EMPTY;
            res_reg.occupancy     <= count_reg;
            res_reg.is_empty      <= !nonempty;
        end
    end

    // status to the controller
    assign stat.scan_done = !scan_issue && !rd_pend_reg;
    assign stat.dup_found = dup_reg;
    assign stat.full      = (count_reg >= cap_eff);
    assign stat.nonempty  = nonempty;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[sim/dbmf_status_checker.sv]
// status checker for the duplicate-filtering message fifo: predicts and compares items
module dbmf_status_checker import dbmf_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    dbmf_in_if               in_ch,
    dbmf_out_if              out_ch,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               outstanding
);

    // shadow copy of the ring, its pointers and the capacity register
    logic signed [MSG_W-1:0] ring [DEPTH];
    int                      oldest;
    int                      count;
    logic [CAP_W-1:0]        capacity;
    dbmf_res_t               pending_status [$];

    function automatic int ring_slot(input int offset);
        return (oldest + offset) % DEPTH;
    endfunction

    // remove the oldest entry and return it
    function automatic logic signed [MSG_W-1:0] take_oldest();
        logic signed [MSG_W-1:0] v;
        v = ring[ring_slot(0)];
        oldest = ring_slot(1);
        count = count - 1;
        return v;
    endfunction

    // apply one item to the shadow queue and build the status it should produce
    function automatic dbmf_res_t predict_status(input logic [ACT_W-1:0] act,
                                                 input logic signed [MSG_W-1:0] msg);
        dbmf_res_t st;
        int        limit;
        logic      found;
        st = '0;
        found = 1'b0;
        // zero acts as one, anything above the ring size acts as the ring size
        if (capacity == '0)
            limit = 1;
        else if (int'(capacity) > DEPTH)
            limit = DEPTH;
        else
            limit = int'(capacity);

        if (act == ACT_OFFER)
        begin
            for (int i = 0; i < count; i++)
            begin
                if (ring[ring_slot(i)] == msg)
                    found = 1'b1;
            end
            if (found)
                st.was_duplicate = 1'b1;
            else
            begin
                // at most one eviction per offer, even when capacity was lowered
                if (count >= limit)
                begin
                    st.evicted_value = take_oldest();
                    st.did_evict = 1'b1;
                end
                ring[ring_slot(count)] = msg;
                count = count + 1;
                st.was_stored = 1'b1;
            end
        end
        else if (act == ACT_POP)
        begin
            if (count > 0)
                st.popped_value = take_oldest();
        end
        else if (act == ACT_CLEAR)
        begin
            count = 0;
            oldest = 0;
        end

        // status after the step
        if (count == 0)
        begin
            st.head_value = HEAD_EMPTY;
            st.tail_value = TAIL_EMPTY;
        end
        else
        begin
            st.head_value = ring[ring_slot(0)];
            st.tail_value = ring[ring_slot(count - 1)];
        end
        st.occupancy = CNT_W'(count);
        st.is_empty = (count == 0);
        return st;
    endfunction

    task automatic check_field(input string name, input logic [MSG_W-1:0] want,
                               input logic [MSG_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // watch config writes, accepted inputs and accepted status items
    always @(posedge clk or negedge rst_n)
    begin
        dbmf_res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                ring[i] = '0;
            oldest = 0;
            count = 0;
            capacity = CAP_RESET;
            pending_status.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;

            if (in_ch.valid && in_ch.ready)
                pending_status.push_back(predict_status(in_ch.action, in_ch.message_value));

            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_status.size() == 0)
                begin
                    $display("%0t: unexpected status item: expected none actual head %0h occ %0d",
                             $time, out_ch.head_value, out_ch.occupancy);
                    fail_count++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("was_duplicate", MSG_W'(want.was_duplicate),
                                MSG_W'(out_ch.was_duplicate));
                    check_field("was_stored", MSG_W'(want.was_stored),
                                MSG_W'(out_ch.was_stored));
                    check_field("did_evict", MSG_W'(want.did_evict), MSG_W'(out_ch.did_evict));
                    check_field("evicted_value", want.evicted_value, out_ch.evicted_value);
                    check_field("popped_value", want.popped_value, out_ch.popped_value);
                    check_field("head_value", want.head_value, out_ch.head_value);
                    check_field("tail_value", want.tail_value, out_ch.tail_value);
                    check_field("occupancy", MSG_W'(want.occupancy), MSG_W'(out_ch.occupancy));
                    check_field("is_empty", MSG_W'(want.is_empty), MSG_W'(out_ch.is_empty));
                end
            end
            outstanding = pending_status.size();
        end
    end

endmodule

[sim/tb_dedup_bounded_message_fifo.sv]
// testbench top of the duplicate-filtering message fifo: stimulus, idling and verdict
module tb_dedup_bounded_message_fifo;
    import dbmf_pkg::*;

    localparam int               DEPTH         = 16;
    localparam logic [ACT_W-1:0] ACT_UNUSED    = 2'd3;
    localparam int               PHASES        = 9;
    localparam int               PHASE_ITEMS   = 195;
    localparam int               LONG_HOLD     = 300;
    localparam int               DRAIN_CYCLES  = 30;
    localparam int               TIMEOUT_UNITS = 1200000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    bit               gaps_on;
    bit               stall_on;
    bit               long_hold_req;

    dbmf_in_if  in_ch ();
    dbmf_out_if out_ch ();

    dedup_bounded_message_fifo #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    dbmf_status_checker #(.DEPTH(DEPTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #TIMEOUT_UNITS;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: short random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // message values: a small pool to provoke duplicates, or anything at all
    function automatic logic signed [MSG_W-1:0] pick_message();
        logic signed [MSG_W-1:0] pool [8];
        pool = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh5555, -16'sh5556,
                 16'sh0001, 16'sh0100};
        case ($urandom_range(0, 9))
            0, 1, 2: return pool[$urandom_range(0, 7)];
            3, 4:    return MSG_W'($signed($urandom_range(0, 15)) - 8);
            default: return MSG_W'($urandom);
        endcase
    endfunction

    // offer one item, with an optional idle burst before it, and wait until taken
    task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [MSG_W-1:0] msg);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.message_value <= msg;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every expected status item has arrived
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [CAP_W-1:0] cap_plan [PHASES];
        int               r;
        logic [ACT_W-1:0] act;
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd16, 5'd8};
        cap_plan[7] = CAP_W'($urandom_range(0, 31));
        gaps_on = 1'b1;
        stall_on = 1'b1;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_OFFER;
        in_ch.message_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, extremes, duplicates, unused code, clear
        send_item(ACT_POP, 16'sh1234);
        send_item(ACT_CLEAR, -16'sh1);
        send_item(ACT_UNUSED, 16'sh7fff);
        send_item(ACT_OFFER, 16'sh7fff);
        send_item(ACT_OFFER, -16'sh8000);
        send_item(ACT_OFFER, 16'sh0000);
        send_item(ACT_OFFER, -16'sh0001);
        send_item(ACT_OFFER, 16'sh7fff);
        send_item(ACT_OFFER, -16'sh8000);
        send_item(ACT_POP, 16'sh0000);
        send_item(ACT_OFFER, 16'sh7fff);
        send_item(ACT_UNUSED, -16'sh8000);
        send_item(ACT_CLEAR, 16'sh0000);
        send_item(ACT_OFFER, -16'sh0001);
        send_item(ACT_OFFER, -16'sh0001);

        // directed: zero capacity acts as one, eviction on every new value
        write_capacity(5'd0);
        send_item(ACT_OFFER, 16'sh0005);
        send_item(ACT_OFFER, 16'sh0006);
        send_item(ACT_OFFER, 16'sh0006);
        send_item(ACT_POP, 16'sh0000);

        // directed: capacity lowered below the occupancy
        write_capacity(5'd16);
        send_item(ACT_OFFER, 16'sh0001);
        send_item(ACT_OFFER, 16'sh0002);
        send_item(ACT_OFFER, 16'sh0003);
        write_capacity(5'd2);
        send_item(ACT_OFFER, 16'sh0004);
        send_item(ACT_POP, 16'sh0000);

        // random phases, one capacity setting each
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(cap_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // idling on and off in stretches, none in the last phase
                if (n % 40 == 0)
                begin
                    gaps_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
                    stall_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
                end
                if (n == 60 && p % 3 == 1)
                    long_hold_req = 1'b1;
                if (n == 120)
                    settle();
                r = $urandom_range(0, 99);
                if (r < 64)
                    act = ACT_OFFER;
                else if (r < 86)
                    act = ACT_POP;
                else if (r < 93)
                    act = ACT_CLEAR;
                else
                    act = ACT_UNUSED;
                send_item(act, pick_message());
            end
        end

        // drain and verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/dbmf_pkg.sv
rtl/core/dbmf_in_if.sv
rtl/core/dbmf_out_if.sv
rtl/core/dbmf_ctrl.sv
rtl/core/dbmf_dpath.sv
rtl/core/dedup_bounded_message_fifo.sv
sim/dbmf_status_checker.sv
sim/tb_dedup_bounded_message_fifo.sv
